>>> design/pds_pkg.sv
// Package for the percent-decode stream: character codes, result types and hex helpers.
`timescale 1ns / 1ps

package pds_pkg;

    // Character codes that the decoder recognises or produces.
    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_NUL     = 8'h00;

    // Most results that one input byte can cause.
    localparam int unsigned MAX_RESULTS = 3;

    // Lookahead held between input bytes.
    typedef enum logic [1:0] {
        HOLD_NONE  = 2'd0,
        HOLD_PCT   = 2'd1,
        HOLD_DIGIT = 2'd2
    } hold_t;

    // One result transfer.
    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       last;
    } result_t;

    // All results caused by one input byte, in output order from slot 0.
    typedef struct packed {
        result_t [MAX_RESULTS-1:0] slot;
        logic [1:0]                count;
    } burst_t;

    // True for 0-9, A-F and a-f.
    function automatic logic is_hex(logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) ||
               ((c >= 8'h41) && (c <= 8'h46)) ||
               ((c >= 8'h61) && (c <= 8'h66));
    endfunction

    // Value of a hex digit; letters of both cases share the low nibble pattern.
    function automatic logic [3:0] hex_nibble(logic [7:0] c);
        logic [3:0] v;
        if (c[6]) begin
            v = c[3:0] + 4'd9;
        end else begin
            v = c[3:0];
        end
        return v;
    endfunction

    // Append a data byte to a burst; bytes beyond the third are dropped.
    function automatic burst_t push_byte(burst_t b, logic [7:0] v);
        burst_t r;
        r = b;
        if (b.count != 2'(MAX_RESULTS)) begin
            r.slot[b.count].data = v;
            r.slot[b.count].has  = 1'b1;
            r.slot[b.count].last = 1'b0;
            r.count              = b.count + 2'd1;
        end
        return r;
    endfunction

endpackage

>>> design/percent_decode_stream.sv
// Top level of the streaming percent decoder: input handshake and result buffer.
// Latency: the first result of a byte is offered in the cycle after its transfer.
// Throughput: one byte per cycle while each byte gives at most one result and
// m_tready stays high; a byte that gives more results holds s_tready low while
// the three-entry result buffer drains through the master port.
// Reset: clears the result buffer and the lookahead and selects query mode.
`timescale 1ns / 1ps

module percent_decode_stream
    import pds_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,  // [7:0] in_byte
    input  logic       s_tlast,  // in_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,  // [7:0] out_byte
    output logic       m_tuser,  // [0] has_byte
    output logic       m_tlast   // out_last
);

    burst_t                    burst;
    result_t [MAX_RESULTS-1:0] slot_reg, slot_next;
    logic [1:0]                count_reg, count_next;
    logic                      in_accept;
    logic                      out_pop;

    pds_decoder u_decoder (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_byte     (s_tdata),
        .in_last     (s_tlast),
        .in_accept   (in_accept),
        .burst       (burst)
    );

    // Take a new byte when the buffer is empty or its last result leaves now.
    assign m_tvalid  = (count_reg != 2'd0);
    assign out_pop   = m_tvalid && m_tready;
    assign s_tready  = (count_reg == 2'd0) || ((count_reg == 2'd1) && m_tready);
    assign in_accept = s_tvalid && s_tready;

    // Load a fresh burst, or shift the buffer down by one on each output transfer.
    always_comb begin
        slot_next  = slot_reg;
        count_next = count_reg;
        if (in_accept) begin
            slot_next  = burst.slot;
            count_next = burst.count;
        end else if (out_pop) begin
            slot_next[0] = slot_reg[1];
            slot_next[1] = slot_reg[2];
            count_next   = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg <= slot_next;
    end

    assign m_tdata = slot_reg[0].data;
    assign m_tuser = slot_reg[0].has;
    assign m_tlast = slot_reg[0].last;

    // An empty end marker is always the final result of a string.
    a_marker_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> m_tlast)
        else $error("empty result without end flag");

    // The final byte of a string always leaves at least one result behind.
    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> m_tvalid)
        else $error("final byte produced no result");

    // Input is held off while more than one result is still queued.
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg > 2'd1) |-> !s_tready)
        else $error("input accepted with results still queued");

endmodule

>>> design/pds_decoder.sv
// Decoder core: lookahead state, mode register and the results of each accepted byte.
`timescale 1ns / 1ps

module pds_decoder
    import pds_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  logic       in_accept,
    output burst_t     burst
);

    hold_t      held_count_reg, held_count_next;
    logic [7:0] held_digit_reg, held_digit_next;
    logic       plus_is_space_reg;
    logic       plain_en;
    logic [7:0] escaped;

    // Mode register, written through the configuration port.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plus_is_space_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            plus_is_space_reg <= cfg_wr_data;
        end
    end

    // Lookahead state advances once per accepted transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_count_reg <= HOLD_NONE;
            held_digit_reg <= CHAR_NUL;
        end else if (in_accept) begin
            held_count_reg <= held_count_next;
            held_digit_reg <= held_digit_next;
        end
    end

    assign escaped = {hex_nibble(held_digit_reg), hex_nibble(in_byte)};

    // Work out the results of the current byte and the state it leaves.
    always_comb begin
        burst           = '0;
        held_count_next = HOLD_NONE;
        held_digit_next = held_digit_reg;
        plain_en        = 1'b0;

        unique case (held_count_reg)
            HOLD_PCT: begin
                if (is_hex(in_byte)) begin
                    held_count_next = HOLD_DIGIT;
                    held_digit_next = in_byte;
                end else begin
                    burst    = push_byte(burst, CHAR_PERCENT);
                    plain_en = 1'b1;
                end
            end
            HOLD_DIGIT: begin
                held_digit_next = CHAR_NUL;
                if (is_hex(in_byte)) begin
                    // A decoded zero byte is dropped.
                    if (escaped != CHAR_NUL) begin
                        burst = push_byte(burst, escaped);
                    end
                end else begin
                    burst    = push_byte(burst, CHAR_PERCENT);
                    burst    = push_byte(burst, held_digit_reg);
                    plain_en = 1'b1;
                end
            end
            default: begin
                plain_en = 1'b1;
            end
        endcase

        // Ordinary handling of the byte when no escape consumes it.
        if (plain_en) begin
            if (in_byte == CHAR_PERCENT) begin
                held_count_next = HOLD_PCT;
            end else if (plus_is_space_reg && (in_byte == CHAR_PLUS)) begin
                burst = push_byte(burst, CHAR_SPACE);
            end else begin
                burst = push_byte(burst, in_byte);
            end
        end

        // End of string: flush the lookahead literally and flag the final result.
        if (in_last) begin
            if (held_count_next == HOLD_PCT) begin
                burst = push_byte(burst, CHAR_PERCENT);
            end else if (held_count_next == HOLD_DIGIT) begin
                burst = push_byte(burst, CHAR_PERCENT);
                burst = push_byte(burst, held_digit_next);
            end
            held_count_next = HOLD_NONE;
            held_digit_next = CHAR_NUL;
            if (burst.count == 2'd0) begin
                burst.slot[0] = '{data: CHAR_NUL, has: 1'b0, last: 1'b0};
                burst.count   = 2'd1;
            end
            burst.slot[burst.count - 2'd1].last = 1'b1;
        end
    end

endmodule
